@@ rtl/core/rlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and constants of the cell run-length rule checker.
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam int CellsPerByte = 8;
  localparam int CellCountW   = 4;
  localparam int LimitW       = 16;
  localparam int ResultW      = 24;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrW    = 2;
  localparam int InDataW      = 16;
  localparam int OutDataW     = 176;
  localparam int CfgIndexW    = 3;
  localparam int CfgDataW     = 16;

  localparam logic [1:0] PrevNone = 2'd2;
  localparam logic [1:0] PrevOne  = 2'd1;

  localparam logic [CellCountW-1:0] MaxCells = CellCountW'(CellsPerByte);

  typedef enum logic [CfgIndexW-1:0] {
    REG_LSB_FIRST      = 3'd0,
    REG_ZERO_LIMIT_ON  = 3'd1,
    REG_ZERO_RUN_LIMIT = 3'd2,
    REG_ONE_LIMIT_ON   = 3'd3,
    REG_ONE_RUN_LIMIT  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic              lsb_first;
    logic              zero_limit_on;
    logic [LimitW-1:0] zero_run_limit;
    logic              one_limit_on;
    logic [LimitW-1:0] one_run_limit;
  } cfg_t;

  // Cells are held in stream order: bit k is the k-th cell of the byte.
  typedef struct packed {
    logic [CellsPerByte-1:0] cells;
    logic [CellCountW-1:0]   count;
    logic                    last;
  } entry_t;

endpackage

@@ rtl/core/rlc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_front
// Input side: unpacks a byte into cells in stream order and clamps the count.
// ----------------------------------------------------------------------------
module rlc_front (
  input  logic                           lsb_first,
  input  logic [rlc_pkg::InDataW-1:0]    tdata,
  input  logic                           tlast,
  output rlc_pkg::entry_t                entry
);
  import rlc_pkg::*;

  logic [7:0]            cell_byte;
  logic [CellCountW-1:0] valid_cells;

  assign cell_byte   = tdata[7:0];
  assign valid_cells = tdata[11:8];

  always_comb begin
    for (int k = 0; k < CellsPerByte; k++) begin
      entry.cells[k] = lsb_first ? cell_byte[k] : cell_byte[CellsPerByte-1-k];
    end
    entry.count = (valid_cells > MaxCells) ? MaxCells : valid_cells;
    entry.last  = tlast;
  end

endmodule

@@ rtl/core/rlc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_queue
// Small first-in first-out queue between the input side and the checker.
// ----------------------------------------------------------------------------
module rlc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rlc_pkg::entry_t push_entry,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output rlc_pkg::entry_t pop_entry
);
  import rlc_pkg::*;

  entry_t               slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   fill;
  logic                 do_push;
  logic                 do_pop;

  assign not_full  = (fill != (QueuePtrW+1)'(QueueDepth));
  assign not_empty = (fill != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/rlc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlc_back
// Checker: follows runs over up to eight cells a cycle while not stalled, keeps
// the counters and loads the result register on the last byte of a track.
// ----------------------------------------------------------------------------
module rlc_back #(
  parameter int COUNT_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rlc_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  input  rlc_pkg::entry_t              in_entry,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rlc_pkg::OutDataW-1:0] out_data
);
  import rlc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [CellCountW-1:0] b);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, a} + (COUNT_BITS+1)'(b);
    return sum[COUNT_BITS] ? CntMax : sum[COUNT_BITS-1:0];
  endfunction

  function automatic logic [CellCountW-1:0] pop_count(input logic [CellsPerByte-1:0] v);
    logic [CellCountW-1:0] n;
    n = '0;
    for (int k = 0; k < CellsPerByte; k++) begin
      n = n + CellCountW'(v[k]);
    end
    return n;
  endfunction

  logic [1:0]            previous_cell;
  logic [COUNT_BITS-1:0] run_length;
  logic [COUNT_BITS-1:0] cells_seen;
  logic [COUNT_BITS-1:0] ones_seen;
  logic [COUNT_BITS-1:0] pairs_seen;
  logic [COUNT_BITS-1:0] longest_zero_run;
  logic [COUNT_BITS-1:0] longest_one_run;
  logic [COUNT_BITS-1:0] violations_seen;
  logic [COUNT_BITS-1:0] first_violation_at;
  logic                  violation_found;

  logic [1:0]            previous_cell_next;
  logic [COUNT_BITS-1:0] run_length_next;
  logic [COUNT_BITS-1:0] cells_seen_next;
  logic [COUNT_BITS-1:0] ones_seen_next;
  logic [COUNT_BITS-1:0] pairs_seen_next;
  logic [COUNT_BITS-1:0] longest_zero_run_next;
  logic [COUNT_BITS-1:0] longest_one_run_next;
  logic [COUNT_BITS-1:0] violations_seen_next;
  logic [COUNT_BITS-1:0] first_violation_at_next;
  logic                  violation_found_next;

  logic [CellsPerByte-1:0] cells;
  logic [CellsPerByte-1:0] used;
  logic [CellsPerByte-1:0] joined;
  logic [CellsPerByte-1:0] viol;
  logic [CellsPerByte-1:0] pair;
  logic [CellCountW-1:0]   local_run [CellsPerByte];
  logic [COUNT_BITS-1:0]   cell_run  [CellsPerByte];
  logic [COUNT_BITS:0]     joined_sum [CellsPerByte];
  logic [COUNT_BITS-1:0]   joined_zero;
  logic [COUNT_BITS-1:0]   joined_one;
  logic [CellCountW-1:0]   local_zero;
  logic [CellCountW-1:0]   local_one;
  logic [2:0]              first_k;
  logic [2:0]              last_k;
  logic                    take;

  assign in_ready = !in_entry.last || !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign cells    = in_entry.cells;
  assign last_k   = 3'(in_entry.count - 1'b1);

  always_comb begin
    for (int k = 0; k < CellsPerByte; k++) begin
      used[k] = (CellCountW'(k) < in_entry.count);
    end

    // Length of the run inside this byte, and whether it continues the
    // run carried over from the previous byte.
    local_run[0] = CellCountW'(1);
    joined[0]    = (previous_cell == {1'b0, cells[0]});
    pair[0]      = used[0] && cells[0] && (previous_cell == PrevOne);
    for (int k = 1; k < CellsPerByte; k++) begin
      local_run[k] = (cells[k] == cells[k-1]) ? local_run[k-1] + 1'b1 : CellCountW'(1);
      joined[k]    = joined[k-1] && (cells[k] == cells[k-1]);
      pair[k]      = used[k] && cells[k] && cells[k-1];
    end

    for (int k = 0; k < CellsPerByte; k++) begin
      joined_sum[k] = {1'b0, run_length} + (COUNT_BITS+1)'(k + 1);
      if (joined[k]) begin
        cell_run[k] = joined_sum[k][COUNT_BITS] ? CntMax : joined_sum[k][COUNT_BITS-1:0];
      end else begin
        cell_run[k] = COUNT_BITS'(local_run[k]);
      end
      if (cells[k]) begin
        viol[k] = used[k] && cfg.one_limit_on &&
                  (cell_run[k] > COUNT_BITS'(cfg.one_run_limit));
      end else begin
        viol[k] = used[k] && cfg.zero_limit_on &&
                  (cell_run[k] > COUNT_BITS'(cfg.zero_run_limit));
      end
    end

    // Joined runs grow along the byte, so the last one is the longest.
    joined_zero = '0;
    joined_one  = '0;
    local_zero  = '0;
    local_one   = '0;
    for (int k = 0; k < CellsPerByte; k++) begin
      if (used[k] && joined[k]) begin
        if (cells[k]) begin
          joined_one = cell_run[k];
        end else begin
          joined_zero = cell_run[k];
        end
      end
      if (used[k] && !joined[k]) begin
        if (cells[k] && (local_run[k] > local_one)) begin
          local_one = local_run[k];
        end
        if (!cells[k] && (local_run[k] > local_zero)) begin
          local_zero = local_run[k];
        end
      end
    end

    first_k = '0;
    for (int k = CellsPerByte - 1; k >= 0; k--) begin
      if (viol[k]) begin
        first_k = 3'(k);
      end
    end

    longest_zero_run_next = longest_zero_run;
    if (joined_zero > longest_zero_run_next) begin
      longest_zero_run_next = joined_zero;
    end
    if (COUNT_BITS'(local_zero) > longest_zero_run_next) begin
      longest_zero_run_next = COUNT_BITS'(local_zero);
    end
    longest_one_run_next = longest_one_run;
    if (joined_one > longest_one_run_next) begin
      longest_one_run_next = joined_one;
    end
    if (COUNT_BITS'(local_one) > longest_one_run_next) begin
      longest_one_run_next = COUNT_BITS'(local_one);
    end

    cells_seen_next      = sat_add(cells_seen, in_entry.count);
    ones_seen_next       = sat_add(ones_seen, pop_count(cells & used));
    pairs_seen_next      = sat_add(pairs_seen, pop_count(pair));
    violations_seen_next = sat_add(violations_seen, pop_count(viol));

    violation_found_next    = violation_found;
    first_violation_at_next = first_violation_at;
    if (!violation_found && (viol != '0)) begin
      violation_found_next    = 1'b1;
      first_violation_at_next = sat_add(cells_seen, {1'b0, first_k});
    end

    if (in_entry.count != '0) begin
      previous_cell_next = {1'b0, cells[last_k]};
      run_length_next    = cell_run[last_k];
    end else begin
      previous_cell_next = previous_cell;
      run_length_next    = run_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_entry.last)) begin
      previous_cell      <= PrevNone;
      run_length         <= '0;
      cells_seen         <= '0;
      ones_seen          <= '0;
      pairs_seen         <= '0;
      longest_zero_run   <= '0;
      longest_one_run    <= '0;
      violations_seen    <= '0;
      first_violation_at <= '0;
      violation_found    <= 1'b0;
    end else if (take) begin
      previous_cell      <= previous_cell_next;
      run_length         <= run_length_next;
      cells_seen         <= cells_seen_next;
      ones_seen          <= ones_seen_next;
      pairs_seen         <= pairs_seen_next;
      longest_zero_run   <= longest_zero_run_next;
      longest_one_run    <= longest_one_run_next;
      violations_seen    <= violations_seen_next;
      first_violation_at <= first_violation_at_next;
      violation_found    <= violation_found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && in_entry.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_entry.last) begin
      out_data <= {6'b0,
                   (violations_seen_next == '0),
                   ResultW'(first_violation_at_next),
                   violation_found_next,
                   ResultW'(violations_seen_next),
                   ResultW'(longest_one_run_next),
                   ResultW'(longest_zero_run_next),
                   ResultW'(pairs_seen_next),
                   ResultW'(ones_seen_next),
                   ResultW'(cells_seen_next)};
    end
  end

endmodule

@@ rtl/core/cell_run_length_rule_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_run_length_rule_checker_top
// Checks a packed bitcell stream against zero-run and one-run limits and
// reports counts, longest runs and the first violating cell per track.
// ----------------------------------------------------------------------------
//  Channel | Direction | Signals                     | Moves
//  s_      | in        | tvalid tready tdata tlast   | one byte of up to 8 cells
//  m_      | out       | tvalid tready tdata         | one result per track
//  cfg_    | in        | valid ready index data      | one register write
//
// One byte is taken every cycle while the queue is not full; the valid cells of a
// byte are checked together, so one transfer per cycle unless stalled.
// A result is registered when the checker takes the queued byte carrying tlast.
// Reset clears the queue, the counters and the configuration registers.
// A stalled result holds the checker on the next last byte only; the
// four-entry queue keeps taking bytes until it is full.
// ----------------------------------------------------------------------------
module cell_run_length_rule_checker_top #(
  parameter int COUNT_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  // cell_byte [7:0], valid_cells [11:8], zero fill above
  input  logic [rlc_pkg::InDataW-1:0]    s_tdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic                           s_tlast,
  // cell_count [23:0], ones_count [47:24], pair_count [71:48],
  // max_zero_run [95:72], max_one_run [119:96], violation_count [143:120],
  // violation_seen [144], first_violation_index [168:145], rule_holds [169]
  output logic [rlc_pkg::OutDataW-1:0]   m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlc_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [rlc_pkg::CfgDataW-1:0]   cfg_data
);
  import rlc_pkg::*;

  cfg_t   cfg;
  entry_t front_entry;
  entry_t queue_entry;
  logic   queue_not_empty;
  logic   back_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LSB_FIRST:      cfg.lsb_first      <= cfg_data[0];
        REG_ZERO_LIMIT_ON:  cfg.zero_limit_on  <= cfg_data[0];
        REG_ZERO_RUN_LIMIT: cfg.zero_run_limit <= cfg_data[LimitW-1:0];
        REG_ONE_LIMIT_ON:   cfg.one_limit_on   <= cfg_data[0];
        REG_ONE_RUN_LIMIT:  cfg.one_run_limit  <= cfg_data[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  rlc_front u_front (
    .lsb_first (cfg.lsb_first),
    .tdata     (s_tdata),
    .tlast     (s_tlast),
    .entry     (front_entry)
  );

  rlc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_entry (front_entry),
    .not_full   (s_tready),
    .pop        (back_ready),
    .not_empty  (queue_not_empty),
    .pop_entry  (queue_entry)
  );

  rlc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (queue_not_empty),
    .in_entry  (queue_entry),
    .in_ready  (back_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
